@@ hw/rtl/plpl_pkg.sv @@
// Package for the piecewise-linear path lookup block.
// Holds request and status codes, widths and the joint record type.
// No dependencies; every other file imports it.
package plpl_pkg;

	localparam int MAX_JOINTS = 1024;
	localparam int IDX_W      = $clog2(MAX_JOINTS);
	localparam int SEG_W      = 10;
	localparam int TIME_W     = 32;
	localparam int POS_W      = 48;
	localparam int DELTA_W    = 32;
	localparam int FRAC_W     = 16;

	localparam logic [1:0] REQ_CLEAR  = 2'd0;
	localparam logic [1:0] REQ_APPEND = 2'd1;
	localparam logic [1:0] REQ_QUERY  = 2'd2;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_CLAMPED = 3'd1;
	localparam logic [2:0] ST_EMPTY   = 3'd2;
	localparam logic [2:0] ST_FULL    = 3'd3;
	localparam logic [2:0] ST_NOT_INC = 3'd4;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_JOINTS - 1);

	typedef struct packed {
		logic [TIME_W-1:0]       jtime;
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
	} joint_t;

endpackage

@@ hw/rtl/plpl_req_if.sv @@
// Request channel of the path lookup block: valid/ready plus the request fields.
// Depends on plpl_pkg for field widths.
interface plpl_req_if import plpl_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [1:0]                req_type;
	logic [TIME_W-1:0]         sample_time;
	logic signed [DELTA_W-1:0] delta_x;
	logic signed [DELTA_W-1:0] delta_y;

	modport source (output valid, req_type, sample_time, delta_x, delta_y, input ready);
	modport sink (input valid, req_type, sample_time, delta_x, delta_y, output ready);
endinterface

@@ hw/rtl/plpl_rsp_if.sv @@
// Result channel of the path lookup block: valid/ready plus the result fields.
// Depends on plpl_pkg for field widths.
interface plpl_rsp_if import plpl_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [2:0]              status;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic [SEG_W-1:0]        segment_index;

	modport source (output valid, status, pos_x, pos_y, segment_index, input ready);
	modport sink (input valid, status, pos_x, pos_y, segment_index, output ready);
endinterface

@@ hw/rtl/piecewise_linear_path_lookup.sv @@
// Channel  Dir  Payload
// req      in   req_type, sample_time, delta_x, delta_y
// rsp      out  status, pos_x, pos_y, segment_index
//
// Clear, append and unused requests pass from the execute state straight to the output state;
// the result is loaded into the output register there once that register is free.
// A query that falls inside the path runs a binary search, each probe passing through
// the probe and compare states on the joint memory read port, then two joint reads,
// the fraction divide, and the magnitude, scale and add steps.
// Reset clears the path to the origin joint alone; no clearing pass is needed.
// A finished result waits in the output register while the next request is taken.
// Depends on plpl_pkg, plpl_req_if, plpl_rsp_if, plpl_joint_mem, plpl_divider.
module piecewise_linear_path_lookup
	import plpl_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	plpl_req_if.sink   req,
	plpl_rsp_if.source rsp
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_EXEC  = 4'd1;
	localparam logic [3:0] S_PROBE = 4'd2;
	localparam logic [3:0] S_CMP   = 4'd3;
	localparam logic [3:0] S_RDA   = 4'd4;
	localparam logic [3:0] S_RDB   = 4'd5;
	localparam logic [3:0] S_CAPB  = 4'd6;
	localparam logic [3:0] S_DIV   = 4'd7;
	localparam logic [3:0] S_MUL   = 4'd8;
	localparam logic [3:0] S_SCALE = 4'd9;
	localparam logic [3:0] S_ADD   = 4'd10;
	localparam logic [3:0] S_OUT   = 4'd11;

	logic [3:0] state_q;

	logic [1:0]                type_q;
	logic [TIME_W-1:0]         t_q;
	logic signed [DELTA_W-1:0] dx_q;
	logic signed [DELTA_W-1:0] dy_q;

	logic [IDX_W-1:0] count_q;
	joint_t           last_q;
	logic [IDX_W-1:0] lo_q;
	logic [IDX_W-1:0] hi_q;
	joint_t           a_q;
	joint_t           b_q;
	logic [FRAC_W-1:0] frac_q;
	logic             neg_x_q;
	logic             neg_y_q;
	logic [POS_W-1:0] mag_x_q;
	logic [POS_W-1:0] mag_y_q;
	logic [POS_W-1:0] step_x_q;
	logic [POS_W-1:0] step_y_q;

	logic [2:0]              res_status_q;
	logic signed [POS_W-1:0] res_x_q;
	logic signed [POS_W-1:0] res_y_q;
	logic [IDX_W-1:0]        res_idx_q;

	logic                    out_valid_q;
	logic [2:0]              out_status_q;
	logic signed [POS_W-1:0] out_x_q;
	logic signed [POS_W-1:0] out_y_q;
	logic [SEG_W-1:0]        out_seg_q;

	logic             req_fire;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	joint_t           mem_wdata;
	logic [IDX_W-1:0] mem_raddr;
	joint_t           mem_rdata;
	logic [IDX_W:0]   span;
	logic [IDX_W-1:0] mid;
	logic             probe_le;
	logic             div_start;
	logic             div_done;
	logic [FRAC_W-1:0] div_quo;
	logic signed [POS_W:0] sum_x;
	logic signed [POS_W:0] sum_y;
	logic signed [POS_W-1:0] sat_x;
	logic signed [POS_W-1:0] sat_y;
	logic signed [POS_W:0] dif_x;
	logic signed [POS_W:0] dif_y;
	logic [POS_W+FRAC_W-1:0] prod_x;
	logic [POS_W+FRAC_W-1:0] prod_y;
	logic             slot_free;

	localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign slot_free = !out_valid_q || rsp.ready;

	assign span     = {1'b0, hi_q} - {1'b0, lo_q} + 1'b1;
	assign mid      = lo_q + IDX_W'(span >> 1);
	assign probe_le = mem_rdata.jtime <= t_q;

	assign sum_x = POS_W'(last_q.x) + (POS_W+1)'(dx_q);
	assign sum_y = POS_W'(last_q.y) + (POS_W+1)'(dy_q);
	always_comb begin
		sat_x = sum_x[POS_W-1:0];
		if (sum_x[POS_W] != sum_x[POS_W-1]) begin
			sat_x = sum_x[POS_W] ? POS_MIN : POS_MAX;
		end
		sat_y = sum_y[POS_W-1:0];
		if (sum_y[POS_W] != sum_y[POS_W-1]) begin
			sat_y = sum_y[POS_W] ? POS_MIN : POS_MAX;
		end
	end

	assign dif_x  = (POS_W+1)'(b_q.x) - (POS_W+1)'(a_q.x);
	assign dif_y  = (POS_W+1)'(b_q.y) - (POS_W+1)'(a_q.y);
	assign prod_x = mag_x_q * frac_q;
	assign prod_y = mag_y_q * frac_q;

	// Appends are the only writes; they land at the entry after the last joint.
	assign mem_we    = (state_q == S_EXEC) && (type_q == REQ_APPEND)
		&& (count_q != LAST_IDX) && (t_q > last_q.jtime);
	assign mem_waddr = count_q + 1'b1;
	assign mem_wdata = '{jtime: t_q, x: sat_x, y: sat_y};

	always_comb begin
		case (state_q)
			S_RDB:   mem_raddr = lo_q + 1'b1;
			S_RDA:   mem_raddr = lo_q;
			default: mem_raddr = mid;
		endcase
	end

	assign div_start = (state_q == S_CAPB);

	plpl_joint_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	plpl_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (t_q - a_q.jtime),
		.den    (mem_rdata.jtime - a_q.jtime),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_OUT) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_OUT;
					case (type_q)
						REQ_CLEAR: begin
							count_q <= '0;
							last_q  <= '0;
						end
						REQ_APPEND: begin
							if (mem_we) begin
								count_q <= mem_waddr;
								last_q  <= mem_wdata;
							end
						end
						REQ_QUERY: begin
							if (count_q != '0 && t_q < last_q.jtime) begin
								state_q <= (count_q == IDX_W'(1)) ? S_RDA : S_PROBE;
							end
						end
						default: begin
							state_q <= S_OUT;
						end
					endcase
				end
				S_PROBE: state_q <= S_CMP;
				S_CMP: begin
					if (probe_le) begin
						state_q <= (mid < hi_q) ? S_PROBE : S_RDA;
					end else begin
						state_q <= (lo_q < mid - 1'b1) ? S_PROBE : S_RDA;
					end
				end
				S_RDA:   state_q <= S_RDB;
				S_RDB:   state_q <= S_CAPB;
				S_CAPB:  state_q <= S_DIV;
				S_DIV: begin
					if (div_done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL:   state_q <= S_SCALE;
				S_SCALE: state_q <= S_ADD;
				S_ADD:   state_q <= S_OUT;
				S_OUT: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			type_q <= req.req_type;
			t_q    <= req.sample_time;
			dx_q   <= req.delta_x;
			dy_q   <= req.delta_y;
		end
		case (state_q)
			S_EXEC: begin
				lo_q         <= '0;
				hi_q         <= count_q - 1'b1;
				res_status_q <= ST_OK;
				res_x_q      <= '0;
				res_y_q      <= '0;
				res_idx_q    <= '0;
				if (type_q == REQ_APPEND) begin
					res_x_q   <= last_q.x;
					res_y_q   <= last_q.y;
					res_idx_q <= count_q;
					if (count_q == LAST_IDX) begin
						res_status_q <= ST_FULL;
					end else if (!mem_we) begin
						res_status_q <= ST_NOT_INC;
					end else begin
						res_x_q   <= sat_x;
						res_y_q   <= sat_y;
						res_idx_q <= mem_waddr;
					end
				end else if (type_q == REQ_QUERY) begin
					if (count_q == '0) begin
						res_status_q <= ST_EMPTY;
					end else if (t_q >= last_q.jtime) begin
						res_status_q <= (t_q > last_q.jtime) ? ST_CLAMPED : ST_OK;
						res_x_q      <= last_q.x;
						res_y_q      <= last_q.y;
						res_idx_q    <= count_q;
					end
				end
			end
			S_CMP: begin
				if (probe_le) begin
					lo_q <= mid;
				end else begin
					hi_q <= mid - 1'b1;
				end
			end
			S_RDB: a_q <= mem_rdata;
			S_CAPB: b_q <= mem_rdata;
			S_DIV: frac_q <= div_quo;
			S_MUL: begin
				neg_x_q <= dif_x[POS_W];
				neg_y_q <= dif_y[POS_W];
				mag_x_q <= dif_x[POS_W] ? POS_W'(-dif_x) : POS_W'(dif_x);
				mag_y_q <= dif_y[POS_W] ? POS_W'(-dif_y) : POS_W'(dif_y);
			end
			S_SCALE: begin
				step_x_q <= prod_x[POS_W+FRAC_W-1:FRAC_W];
				step_y_q <= prod_y[POS_W+FRAC_W-1:FRAC_W];
			end
			S_ADD: begin
				res_status_q <= ST_OK;
				res_idx_q    <= lo_q;
				res_x_q <= neg_x_q ? a_q.x - $signed(step_x_q) : a_q.x + $signed(step_x_q);
				res_y_q <= neg_y_q ? a_q.y - $signed(step_y_q) : a_q.y + $signed(step_y_q);
			end
			S_OUT: begin
				if (slot_free) begin
					out_status_q <= res_status_q;
					out_x_q      <= res_x_q;
					out_y_q      <= res_y_q;
					out_seg_q    <= SEG_W'(res_idx_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.pos_x         = out_x_q;
	assign rsp.pos_y         = out_y_q;
	assign rsp.segment_index = out_seg_q;

`ifndef ASSERT_OFF
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> (state_q == S_EXEC))
		else $error("request accepted but execution did not start");

	a_search_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> (lo_q <= hi_q) && (hi_q < count_q))
		else $error("binary search bounds out of order");

	a_div_in_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside the divide state");

	a_write_grows_path: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> (count_q == $past(count_q) + 1'b1))
		else $error("joint written without growing the path");

	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) && out_valid_q && !rsp.ready |=> (state_q == S_OUT))
		else $error("result left while output register occupied");
`endif

endmodule

@@ hw/rtl/plpl_joint_mem.sv @@
// Joint store: one write port, one read port with registered read data.
// Joint 0 is never written and always reads as the origin. Depends on plpl_pkg.
module plpl_joint_mem
	import plpl_pkg::*;
(
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  joint_t           wdata,
	input  logic [IDX_W-1:0] raddr,
	output joint_t           rdata
);

	joint_t mem [MAX_JOINTS];
	joint_t rdata_q;
	logic   rzero_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
		rzero_q <= (raddr == '0);
	end

	assign rdata = rzero_q ? joint_t'('0) : rdata_q;

endmodule

@@ hw/rtl/plpl_divider.sv @@
// Restoring divider for the Q0.16 interpolation fraction, one quotient bit per cycle.
// The dividend is known to be below the divisor. Depends on plpl_pkg.
module plpl_divider
	import plpl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [TIME_W-1:0] num,
	input  logic [TIME_W-1:0] den,
	output logic              done,
	output logic [FRAC_W-1:0] quo
);

	logic                      busy_q;
	logic [$clog2(FRAC_W)-1:0] cnt_q;
	logic [TIME_W-1:0]         rem_q;
	logic [TIME_W-1:0]         den_q;
	logic [FRAC_W-1:0]         quo_q;
	logic                      done_q;
	logic [TIME_W:0]           rem2;
	logic                      ge;

	assign rem2 = {rem_q, 1'b0};
	assign ge   = rem2 >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? TIME_W'(rem2 - {1'b0, den_q}) : rem2[TIME_W-1:0];
			quo_q <= {quo_q[FRAC_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
